[sv/grpt_pkg.sv]
// Shared constants, types and helpers of the grid route planner.
package grpt_pkg;

  localparam int unsigned GRID_SIDE_DEF = 5;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned HEAD_W = 2;
  localparam int unsigned DIR_W  = 3;
  localparam int unsigned TURN_W = 3;
  localparam int unsigned COST_W = 14;

  localparam logic [COST_W-1:0] COST_INF    = COST_W'(9999);
  localparam logic [COST_W-1:0] STEP_COST   = COST_W'(100);
  localparam logic [COST_W-1:0] REV_PENALTY = COST_W'(100);

  localparam logic [NODE_W-1:0] NODE_NONE = '1;
  localparam logic [DIR_W-1:0]  DIR_NONE  = DIR_W'(4);

  // request codes
  localparam logic [REQ_W-1:0] REQ_PLAN    = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_BLOCK   = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_UNBLOCK = REQ_W'(2);

  // turn codes
  localparam logic [TURN_W-1:0] TURN_FWD   = TURN_W'(0);
  localparam logic [TURN_W-1:0] TURN_RIGHT = TURN_W'(1);
  localparam logic [TURN_W-1:0] TURN_LEFT  = TURN_W'(2);
  localparam logic [TURN_W-1:0] TURN_BACK  = TURN_W'(3);
  localparam logic [TURN_W-1:0] TURN_END   = TURN_W'(4);

  // command to the search engine
  typedef struct packed {
    logic              go;
    logic [NODE_W-1:0] start;
    logic [NODE_W-1:0] goal;
    logic [DIR_W-1:0]  sdir;
    logic              slot;
  } srch_cmd_t;

  // answer of the search engine
  typedef struct packed {
    logic              done;
    logic [COST_W-1:0] cost;
    logic [NODE_W-1:0] len;
  } srch_rsp_t;

  function automatic logic [TURN_W-1:0] turn_of(input logic [DIR_W-1:0] from_dir,
                                                input logic [DIR_W-1:0] to_dir);
    logic [1:0] diff;
    diff = to_dir[1:0] - from_dir[1:0];
    if (from_dir[2] || to_dir[2]) return TURN_BACK;
    unique case (diff)
      2'd0:    return TURN_FWD;
      2'd1:    return TURN_RIGHT;
      2'd3:    return TURN_LEFT;
      default: return TURN_BACK;
    endcase
  endfunction

endpackage

[sv/grpt_if.sv]
// Request and decision channel interfaces of the grid route planner.
interface grpt_req_if;
  import grpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [HEAD_W-1:0] heading;
  logic [NODE_W-1:0] item_end_a;
  logic [NODE_W-1:0] item_end_b;
  modport source (output valid, req_type, node_a, node_b, heading, item_end_a, item_end_b,
                  input ready);
  modport sink (input valid, req_type, node_a, node_b, heading, item_end_a, item_end_b,
                output ready);
endinterface

interface grpt_dec_if;
  import grpt_pkg::*;
  logic              valid;
  logic              ready;
  logic              leg;
  logic [NODE_W-1:0] route_node;
  logic [TURN_W-1:0] turn_code;
  logic              last;
  modport source (output valid, leg, route_node, turn_code, last, input ready);
  modport sink (input valid, leg, route_node, turn_code, last, output ready);
endinterface

[sv/grpt_geom.sv]
// Grid geometry: neighbour of a node in a heading, and heading between two nodes.
module grpt_geom import grpt_pkg::*; #(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  input  logic [1:0]        dir_i,
  output logic [NODE_W-1:0] nbr_o,
  output logic [DIR_W-1:0]  dir_o
);

  localparam logic [NODE_W-1:0] HOME = NODE_W'(GRID_SIDE * GRID_SIDE);
  localparam logic [NODE_W-1:0] SIDE = NODE_W'(GRID_SIDE);

  function automatic logic [NODE_W-1:0] nbr(input logic [NODE_W-1:0] u,
                                             input logic [1:0] d);
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    // row and column by comparing against the row starts
    row = '0;
    col = u;
    for (int r = 1; r < GRID_SIDE; r++) begin
      if (u >= NODE_W'(r * GRID_SIDE)) begin
        row = NODE_W'(r);
        col = NODE_W'(u - NODE_W'(r * GRID_SIDE));
      end
    end
    if (u == HOME) return (d == 2'd2) ? '0 : NODE_NONE;
    if (u > HOME) return NODE_NONE;
    unique case (d)
      2'd0:    return (row != '0) ? NODE_W'(u - SIDE) : ((u == '0) ? HOME : NODE_NONE);
      2'd1:    return (NODE_W'(col + 1'b1) < SIDE) ? NODE_W'(u + 1'b1) : NODE_NONE;
      2'd2:    return (NODE_W'(row + 1'b1) < SIDE) ? NODE_W'(u + SIDE) : NODE_NONE;
      default: return (col != '0) ? NODE_W'(u - 1'b1) : NODE_NONE;
    endcase
  endfunction

  assign nbr_o = nbr(node_a_i, dir_i);

  // first heading that leads from a to b, lowest wins
  always_comb begin
    logic [NODE_W-1:0] n;
    dir_o = DIR_NONE;
    for (int d = 3; d >= 0; d--) begin
      n = nbr(node_a_i, 2'(d));
      if (n != NODE_NONE && n == node_b_i) dir_o = DIR_W'(d);
    end
  end

endmodule

[sv/grpt_edge_map.sv]
// Open-edge map: one bit per heading and node, block and unblock updates.
module grpt_edge_map import grpt_pkg::*; #(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic              close_i,
  input  logic [NODE_W-1:0] a_i,
  input  logic [NODE_W-1:0] b_i,
  input  logic [1:0]        dir_i,
  input  logic [NODE_W-1:0] rd_node_i,
  output logic [3:0]        rd_open_o
);

  localparam int unsigned NODE_COUNT = GRID_SIDE * GRID_SIDE + 1;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);

  logic [3:0] open_q [NODE_COUNT];

  function automatic logic [3:0] reset_mask(input int unsigned u);
    int unsigned row;
    int unsigned col;
    logic [3:0]  m;
    row = u / GRID_SIDE;
    col = u % GRID_SIDE;
    m[0] = (row > 0) || (u == 0);
    m[1] = (col + 1) < GRID_SIDE;
    m[2] = (row + 1) < GRID_SIDE;
    m[3] = col > 0;
    if (u == GRID_SIDE * GRID_SIDE) m = 4'b0100;
    return m;
  endfunction

  logic [1:0] back_dir;
  assign back_dir = dir_i + 2'd2;

  // close or reopen both halves of one edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < NODE_COUNT; u++) open_q[u] <= reset_mask(u);
    end else if (upd_i) begin
      open_q[a_i[IDX_W-1:0]][dir_i]    <= !close_i;
      open_q[b_i[IDX_W-1:0]][back_dir] <= !close_i;
    end
  end

  assign rd_open_o = (rd_node_i < NODE_W'(NODE_COUNT)) ? open_q[rd_node_i[IDX_W-1:0]] : 4'b0;

endmodule

[sv/grpt_search.sv]
// Shortest-path engine: one node scanned or one heading relaxed per cycle.
module grpt_search import grpt_pkg::*; #(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srch_cmd_t         cmd_i,
  output srch_rsp_t         rsp_o,
  output logic [NODE_W-1:0] edge_node_o,
  input  logic [3:0]        edge_open_i,
  input  logic              rt_slot_i,
  input  logic [NODE_W-1:0] rt_idx_i,
  output logic [NODE_W-1:0] rt_node_o
);

  localparam int unsigned NODE_COUNT = GRID_SIDE * GRID_SIDE + 1;
  localparam int unsigned IDX_W      = $clog2(NODE_COUNT);
  localparam logic [NODE_W-1:0] NODE_LIM = NODE_W'(NODE_COUNT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_REC   = 3'd4;

  logic [2:0]        st_q;
  logic [NODE_W-1:0] idx_q;
  logic [NODE_W-1:0] best_q;
  logic [COST_W-1:0] best_cost_q;
  logic [DIR_W-1:0]  best_head_q;
  logic              have_q;
  logic [NODE_W-1:0] goal_q;
  logic              slot_q;
  logic [NODE_W-1:0] walk_q;
  logic [COST_W-1:0] res_cost_q;
  logic [NODE_W-1:0] len_q;
  logic              done_q;

  // scratch stores; costs, predecessor-valid and visited flags are cleared at the start of every run
  logic [COST_W-1:0] cost_q  [NODE_COUNT];
  logic [NODE_W-1:0] pred_q  [NODE_COUNT];
  logic              predv_q [NODE_COUNT];
  logic [DIR_W-1:0]  ahead_q [NODE_COUNT];
  logic              vis_q   [NODE_COUNT];
  logic [NODE_W-1:0] route_q [2][NODE_COUNT];

  logic [NODE_W-1:0] nbr;
  logic [NODE_W-1:0] rd_node;
  logic [IDX_W-1:0]  rd_ix;
  logic              rd_ok;
  logic [COST_W-1:0] rcost;
  logic [NODE_W-1:0] rpred;
  logic              rpredv;
  logic [DIR_W-1:0]  rhead;
  logic              rvis;
  logic [1:0]        rdir;
  logic [COST_W-1:0] nc;
  logic              relax_ok;
  logic              scan_take;
  logic              pick_stop;
  logic              rec_stop;

  grpt_geom #(.GRID_SIDE(GRID_SIDE)) u_geom (
    .node_a_i (best_q),
    .node_b_i ('0),
    .dir_i    (rdir),
    .nbr_o    (nbr),
    .dir_o    ()
  );

  assign rdir        = idx_q[1:0];
  assign edge_node_o = best_q;

  // single read port on the scratch stores
  always_comb begin
    unique case (st_q)
      S_SCAN:  rd_node = idx_q;
      S_RELAX: rd_node = nbr;
      default: rd_node = walk_q;
    endcase
  end

  assign rd_ok  = rd_node < NODE_LIM;
  assign rd_ix  = rd_node[IDX_W-1:0];
  assign rcost  = rd_ok ? cost_q[rd_ix]  : COST_INF;
  assign rpred  = rd_ok ? pred_q[rd_ix]  : '0;
  assign rpredv = rd_ok ? predv_q[rd_ix] : 1'b0;
  assign rhead  = rd_ok ? ahead_q[rd_ix] : DIR_NONE;
  assign rvis   = rd_ok ? vis_q[rd_ix]   : 1'b1;

  assign scan_take = !rvis && (!have_q || rcost < best_cost_q);
  assign pick_stop = !have_q || best_cost_q == COST_INF || best_q == goal_q;
  assign nc        = best_cost_q + STEP_COST + COST_W'(best_head_q != {1'b0, rdir});
  assign relax_ok  = edge_open_i[rdir] && nbr != NODE_NONE && rd_ok && !rvis && nc < rcost;
  assign rec_stop  = !rpredv || NODE_W'(idx_q + 1'b1) >= NODE_LIM;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      idx_q  <= '0;
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (cmd_i.go) begin
            st_q   <= S_SCAN;
            idx_q  <= '0;
            have_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_take) have_q <= 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_q == NODE_W'(NODE_COUNT - 1)) st_q <= S_PICK;
        end
        S_PICK: begin
          idx_q <= '0;
          st_q  <= pick_stop ? S_REC : S_RELAX;
        end
        S_RELAX: begin
          idx_q <= idx_q + 1'b1;
          if (rdir == 2'd3) begin
            st_q   <= S_SCAN;
            idx_q  <= '0;
            have_q <= 1'b0;
          end
        end
        S_REC: begin
          idx_q <= idx_q + 1'b1;
          if (rec_stop) begin
            st_q   <= S_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // working data and stores
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          for (int i = 0; i < NODE_COUNT; i++) begin
            cost_q[i]  <= COST_INF;
            predv_q[i] <= 1'b0;
            vis_q[i]   <= 1'b0;
          end
          cost_q[cmd_i.start[IDX_W-1:0]]  <= '0;
          ahead_q[cmd_i.start[IDX_W-1:0]] <= cmd_i.sdir;
          goal_q <= cmd_i.goal;
          slot_q <= cmd_i.slot;
        end
      end
      S_SCAN: begin
        if (scan_take) begin
          best_q      <= idx_q;
          best_cost_q <= rcost;
          best_head_q <= rhead;
        end
      end
      S_PICK: begin
        walk_q <= goal_q;
        if (!pick_stop) vis_q[best_q[IDX_W-1:0]] <= 1'b1;
      end
      S_RELAX: begin
        if (relax_ok) begin
          cost_q[rd_ix]  <= nc;
          pred_q[rd_ix]  <= best_q;
          predv_q[rd_ix] <= 1'b1;
          ahead_q[rd_ix] <= {1'b0, rdir};
        end
      end
      S_REC: begin
        route_q[slot_q][idx_q[IDX_W-1:0]] <= walk_q;
        if (idx_q == '0) res_cost_q <= rcost;
        if (rec_stop) len_q <= NODE_W'(idx_q + 1'b1);
        else walk_q <= rpred;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.cost = res_cost_q;
  assign rsp_o.len  = len_q;

  // route stored goal first
  assign rt_node_o = (rt_idx_i < NODE_LIM) ? route_q[rt_slot_i][rt_idx_i[IDX_W-1:0]] : '0;

endmodule

[sv/grid_route_planner_turn_penalty.sv]
// Grid route planner: a block or unblock request updates the edge map. A plan request runs four
// shortest-path searches on one shared engine that scans one node per cycle, two before each
// leg; the decisions of a leg then leave one per cycle while the sink takes them. The
// request channel is not ready until the last decision is in the output register.
module grid_route_planner_turn_penalty import grpt_pkg::*; #(
  parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  grpt_req_if.sink        req_i,
  grpt_dec_if.source      dec_o
);

  localparam int unsigned NODE_COUNT = GRID_SIDE * GRID_SIDE + 1;
  localparam logic [NODE_W-1:0] NODE_LIM = NODE_W'(NODE_COUNT);
  localparam logic [NODE_W-1:0] HOME     = NODE_W'(GRID_SIDE * GRID_SIDE);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_DISP = 4'd1;
  localparam logic [3:0] T_S1   = 4'd2;
  localparam logic [3:0] T_S2   = 4'd3;
  localparam logic [3:0] T_EMIT = 4'd4;
  localparam logic [3:0] T_MID  = 4'd5;
  localparam logic [3:0] T_S3   = 4'd6;
  localparam logic [3:0] T_S4   = 4'd7;
  localparam logic [3:0] T_TURN = 4'd8;

  logic [3:0]        st_q;
  logic [REQ_W-1:0]  typ_q;
  logic [NODE_W-1:0] a_q, b_q, ia_q, ib_q;
  logic [HEAD_W-1:0] h_q;
  logic [COST_W-1:0] c1_q;
  logic [NODE_W-1:0] len1_q, len2_q;
  logic [NODE_W-1:0] entry_q, exit_q;
  logic [DIR_W-1:0]  mid_q;

  logic              go_q;
  logic [NODE_W-1:0] cs_start_q, cs_goal_q;
  logic [DIR_W-1:0]  cs_sdir_q;
  logic              cs_slot_q;

  logic              em_slot_q, em_app_q, leg_q;
  logic [NODE_W-1:0] em_len_q, em_k_q, em_prev_q;
  logic [DIR_W-1:0]  em_cur_q;

  logic              ov_q;
  logic              o_leg_q, o_last_q;
  logic [NODE_W-1:0] o_node_q;
  logic [TURN_W-1:0] o_turn_q;

  srch_cmd_t         cmd;
  srch_rsp_t         rsp;
  logic [NODE_W-1:0] edge_node;
  logic [3:0]        edge_open;
  logic [NODE_W-1:0] rt_idx, rt_node;
  logic [NODE_W-1:0] elem, em_total;
  logic [NODE_W-1:0] g_a, g_b;
  logic [DIR_W-1:0]  gdir;
  logic              out_free;
  logic              edge_req, edge_upd, plan_ok;
  logic [COST_W-1:0] c2_rev;
  logic [DIR_W-1:0]  rev_dir;

  assign req_i.ready = (st_q == T_IDLE);
  assign out_free    = !ov_q || dec_o.ready;

  assign cmd.go    = go_q;
  assign cmd.start = cs_start_q;
  assign cmd.goal  = cs_goal_q;
  assign cmd.sdir  = cs_sdir_q;
  assign cmd.slot  = cs_slot_q;

  // emission walks the stored route from its far end
  assign rt_idx   = NODE_W'(em_len_q - 1'b1 - em_k_q);
  assign elem     = (em_k_q < em_len_q) ? rt_node : exit_q;
  assign em_total = NODE_W'(em_len_q + NODE_W'(em_app_q));

  always_comb begin
    unique case (st_q)
      T_DISP:  begin g_a = a_q;       g_b = b_q;     end
      T_EMIT:  begin g_a = em_prev_q; g_b = elem;    end
      default: begin g_a = entry_q;   g_b = exit_q;  end
    endcase
  end

  assign edge_req = (typ_q == REQ_BLOCK) || (typ_q == REQ_UNBLOCK);
  assign edge_upd = (st_q == T_DISP) && edge_req && a_q < NODE_LIM && b_q < NODE_LIM &&
                    !gdir[2];
  assign plan_ok  = (typ_q == REQ_PLAN) && a_q < NODE_LIM && ia_q < NODE_LIM &&
                    ib_q < NODE_LIM;
  assign c2_rev   = rsp.cost + REV_PENALTY;
  assign rev_dir  = (mid_q == DIR_NONE) ? DIR_NONE : {1'b0, mid_q[1:0] + 2'd2};

  grpt_geom #(.GRID_SIDE(GRID_SIDE)) u_geom (
    .node_a_i (g_a),
    .node_b_i (g_b),
    .dir_i    (2'd0),
    .nbr_o    (),
    .dir_o    (gdir)
  );

  grpt_edge_map #(.GRID_SIDE(GRID_SIDE)) u_edge_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (edge_upd),
    .close_i   (typ_q == REQ_BLOCK),
    .a_i       (a_q),
    .b_i       (b_q),
    .dir_i     (gdir[1:0]),
    .rd_node_i (edge_node),
    .rd_open_o (edge_open)
  );

  grpt_search #(.GRID_SIDE(GRID_SIDE)) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rsp_o       (rsp),
    .edge_node_o (edge_node),
    .edge_open_i (edge_open),
    .rt_slot_i   (em_slot_q),
    .rt_idx_i    (rt_idx),
    .rt_node_o   (rt_node)
  );

  // trip sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= T_IDLE;
      go_q  <= 1'b0;
      ov_q  <= 1'b0;
      em_k_q <= '0;
    end else begin
      go_q <= 1'b0;
      if (dec_o.ready) ov_q <= 1'b0;
      unique case (st_q)
        T_IDLE: begin
          if (req_i.valid) st_q <= T_DISP;
        end
        T_DISP: begin
          if (plan_ok) begin
            go_q <= 1'b1;
            st_q <= T_S1;
          end else begin
            st_q <= T_IDLE;
          end
        end
        T_S1: begin
          if (rsp.done) begin
            go_q <= 1'b1;
            st_q <= T_S2;
          end
        end
        T_S2: begin
          if (rsp.done) begin
            em_k_q <= '0;
            st_q   <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (em_k_q < em_total) begin
            if (em_k_q == '0) em_k_q <= em_k_q + 1'b1;
            else if (out_free) begin
              ov_q   <= 1'b1;
              em_k_q <= em_k_q + 1'b1;
            end
          end else if (out_free) begin
            ov_q <= 1'b1;
            st_q <= leg_q ? T_IDLE : T_MID;
          end
        end
        T_MID: begin
          go_q <= 1'b1;
          st_q <= T_S3;
        end
        T_S3: begin
          if (rsp.done) begin
            go_q <= 1'b1;
            st_q <= T_S4;
          end
        end
        T_S4: begin
          if (rsp.done) begin
            em_k_q <= '0;
            st_q   <= (c1_q <= c2_rev) ? T_EMIT : T_TURN;
          end
        end
        T_TURN: begin
          if (out_free) begin
            ov_q   <= 1'b1;
            em_k_q <= '0;
            st_q   <= T_EMIT;
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  // request, search and emission data
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      T_IDLE: begin
        if (req_i.valid) begin
          typ_q <= req_i.req_type;
          a_q   <= req_i.node_a;
          b_q   <= req_i.node_b;
          h_q   <= req_i.heading;
          ia_q  <= req_i.item_end_a;
          ib_q  <= req_i.item_end_b;
        end
      end
      T_DISP: begin
        cs_start_q <= a_q;
        cs_goal_q  <= ia_q;
        cs_sdir_q  <= {1'b0, h_q};
        cs_slot_q  <= 1'b0;
      end
      T_S1: begin
        if (rsp.done) begin
          c1_q       <= rsp.cost;
          len1_q     <= rsp.len;
          cs_goal_q  <= ib_q;
          cs_slot_q  <= 1'b1;
        end
      end
      T_S2: begin
        if (rsp.done) begin
          em_app_q <= 1'b1;
          em_cur_q <= {1'b0, h_q};
          leg_q    <= 1'b0;
          if (c1_q <= rsp.cost) begin
            em_slot_q <= 1'b0;
            em_len_q  <= len1_q;
            entry_q   <= ia_q;
            exit_q    <= ib_q;
          end else begin
            em_slot_q <= 1'b1;
            em_len_q  <= rsp.len;
            entry_q   <= ib_q;
            exit_q    <= ia_q;
          end
        end
      end
      T_EMIT: begin
        if (em_k_q < em_total) begin
          if (em_k_q == '0) em_prev_q <= elem;
          else if (out_free) begin
            o_leg_q   <= leg_q;
            o_node_q  <= em_prev_q;
            o_turn_q  <= turn_of(em_cur_q, gdir);
            o_last_q  <= 1'b0;
            em_cur_q  <= gdir;
            em_prev_q <= elem;
          end
        end else if (out_free) begin
          o_leg_q  <= leg_q;
          o_node_q <= em_prev_q;
          o_turn_q <= TURN_END;
          o_last_q <= leg_q;
        end
      end
      T_MID: begin
        mid_q      <= gdir;
        cs_start_q <= exit_q;
        cs_goal_q  <= HOME;
        cs_sdir_q  <= gdir;
        cs_slot_q  <= 1'b0;
      end
      T_S3: begin
        if (rsp.done) begin
          c1_q       <= rsp.cost;
          len1_q     <= rsp.len;
          cs_start_q <= entry_q;
          cs_slot_q  <= 1'b1;
        end
      end
      T_S4: begin
        if (rsp.done) begin
          leg_q    <= 1'b1;
          em_app_q <= 1'b0;
          len2_q   <= rsp.len;
          if (c1_q <= c2_rev) begin
            em_slot_q <= 1'b0;
            em_len_q  <= len1_q;
            em_cur_q  <= mid_q;
          end
        end
      end
      T_TURN: begin
        if (out_free) begin
          o_leg_q   <= 1'b1;
          o_node_q  <= exit_q;
          o_turn_q  <= TURN_BACK;
          o_last_q  <= 1'b0;
          em_slot_q <= 1'b1;
          em_len_q  <= len2_q;
          em_cur_q  <= rev_dir;
        end
      end
      default: ;
    endcase
  end

  assign dec_o.valid      = ov_q;
  assign dec_o.leg        = o_leg_q;
  assign dec_o.route_node = o_node_q;
  assign dec_o.turn_code  = o_turn_q;
  assign dec_o.last       = o_last_q;

endmodule

[sv/grpt_chk.sv]
// Port checker of the grid route planner, bound to the top level.
module grpt_chk import grpt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_leg_i,
  input logic [NODE_W-1:0] out_node_i,
  input logic [TURN_W-1:0] out_turn_i,
  input logic              out_last_i
);

  // a transfer on the request side always occupies the block
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request channel ready right after a transfer");

  // hold a stalled decision
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_leg_i, out_node_i, out_turn_i, out_last_i}))
    else $error("stalled decision changed");

  // the trip closes with the end of the home leg
  a_last_is_home_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_leg_i && out_turn_i == TURN_END)
    else $error("last flag on a decision other than the home end");

  a_home_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_leg_i && out_turn_i == TURN_END |-> out_last_i)
    else $error("home leg ended without last flag");

endmodule

bind grid_route_planner_turn_penalty grpt_chk u_grpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (dec_o.valid),
  .out_ready_i (dec_o.ready),
  .out_leg_i   (dec_o.leg),
  .out_node_i  (dec_o.route_node),
  .out_turn_i  (dec_o.turn_code),
  .out_last_i  (dec_o.last)
);

[bench/grid_route_planner_turn_penalty_tb.sv]
// Self-checking bench for the grid route planner: random and directed requests, decision scoreboard.
module grid_route_planner_turn_penalty_tb;
  import grpt_pkg::*;

  localparam int unsigned SIDE      = 5;
  localparam int unsigned NODES     = SIDE * SIDE + 1;
  localparam int unsigned HOME      = SIDE * SIDE;
  localparam int unsigned NO_NODE   = 255;
  localparam int unsigned NO_HEAD   = 4;
  localparam int unsigned UNREACHED = 9999;
  localparam int unsigned HOP_COST  = 100;
  localparam int unsigned BACK_COST = 100;
  localparam int unsigned HEAD_N    = 0;
  localparam int unsigned HEAD_E    = 1;
  localparam int unsigned HEAD_S    = 2;
  localparam int unsigned HEAD_W    = 3;
  localparam logic [REQ_W-1:0] REQ_SPARE = REQ_W'(3);
  localparam int unsigned SETTLE    = 5000;
  localparam int unsigned LIMIT     = 3000000;
  localparam int unsigned N_RANDOM  = 130;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [HEAD_W-1:0] heading;
    logic [NODE_W-1:0] item_end_a;
    logic [NODE_W-1:0] item_end_b;
    bit                drain;
  } request_t;

  typedef struct {
    logic              leg;
    logic [NODE_W-1:0] route_node;
    logic [TURN_W-1:0] turn_code;
    logic              last;
  } decision_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  grpt_req_if req_ch ();
  grpt_dec_if dec_ch ();

  grid_route_planner_turn_penalty #(.GRID_SIDE(SIDE)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .dec_o  (dec_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // planner state mirrored by the bench
  logic [3:0]  open_map [NODES];
  int unsigned dist_tab [NODES];
  int unsigned prev_tab [NODES];
  bit          prev_ok  [NODES];
  int unsigned head_tab [NODES];
  bit          done_tab [NODES];
  int unsigned path_buf [NODES];
  int unsigned path_len;
  int unsigned trip_buf [NODES+2];

  request_t    pending_q [$];
  decision_t   decision_q [$];
  request_t    on_wire;
  int unsigned errors, items_taken, plans_taken, decisions_seen, long_turnrounds;
  int unsigned gap_left, stall_left, cycles;
  bit          hold_sink;

  function automatic int unsigned next_node(int unsigned u, int unsigned d);
    int unsigned row, col;
    row = u / SIDE;
    col = u % SIDE;
    if (u == HOME) return (d == HEAD_S) ? 0 : NO_NODE;
    if (u > HOME) return NO_NODE;
    case (d)
      HEAD_N:  return row > 0 ? u - SIDE : (u == 0 ? HOME : NO_NODE);
      HEAD_E:  return col + 1 < SIDE ? u + 1 : NO_NODE;
      HEAD_S:  return row + 1 < SIDE ? u + SIDE : NO_NODE;
      default: return col > 0 ? u - 1 : NO_NODE;
    endcase
  endfunction

  function automatic int unsigned heading_to(int unsigned a, int unsigned b);
    for (int unsigned d = 0; d < 4; d++)
      if (next_node(a, d) == b) return d;
    return NO_HEAD;
  endfunction

  function automatic logic [TURN_W-1:0] turn_between(int unsigned from_h, int unsigned to_h);
    int unsigned diff;
    diff = (to_h - from_h) & 3;
    if (from_h > 3 || to_h > 3) return TURN_BACK;
    case (diff)
      0:       return TURN_FWD;
      1:       return TURN_RIGHT;
      3:       return TURN_LEFT;
      default: return TURN_BACK;
    endcase
  endfunction

  function automatic void reset_map();
    for (int unsigned u = 0; u < NODES; u++) begin
      open_map[u] = '0;
      for (int unsigned d = 0; d < 4; d++)
        if (next_node(u, d) != NO_NODE) open_map[u][d] = 1'b1;
    end
  endfunction

  // cheapest path with turn penalty, route left in path_buf
  function automatic int unsigned cheapest_path(int unsigned start, int unsigned goal,
                                                int unsigned start_h);
    int unsigned u, v, nc, c, n;
    int unsigned rev [NODES];
    for (int unsigned i = 0; i < NODES; i++) begin
      dist_tab[i] = UNREACHED;
      prev_ok[i]  = 1'b0;
      prev_tab[i] = 0;
      done_tab[i] = 1'b0;
      head_tab[i] = 0;
    end
    dist_tab[start] = 0;
    head_tab[start] = start_h;
    for (int unsigned it = 0; it < NODES; it++) begin
      u = NO_NODE;
      for (int unsigned i = 0; i < NODES; i++)
        if (!done_tab[i] && (u == NO_NODE || dist_tab[i] < dist_tab[u])) u = i;
      if (u == NO_NODE || dist_tab[u] == UNREACHED || u == goal) break;
      done_tab[u] = 1'b1;
      for (int unsigned d = 0; d < 4; d++) begin
        if (!open_map[u][d]) continue;
        v = next_node(u, d);
        if (v >= NODES || done_tab[v]) continue;
        nc = dist_tab[u] + HOP_COST + (head_tab[u] != d ? 1 : 0);
        if (nc < dist_tab[v]) begin
          dist_tab[v] = nc;
          prev_tab[v] = u;
          prev_ok[v]  = 1'b1;
          head_tab[v] = d;
        end
      end
    end
    c = 0;
    n = goal;
    forever begin
      rev[c] = n;
      c++;
      if (!prev_ok[n] || c >= NODES) break;
      n = prev_tab[n];
    end
    for (int unsigned i = 0; i < c; i++) path_buf[i] = rev[c-1-i];
    path_len = c;
    return dist_tab[goal];
  endfunction

  function automatic void push_decision(int unsigned leg, int unsigned node,
                                        logic [TURN_W-1:0] turn, int unsigned fin);
    decision_t e;
    e.leg        = leg[0];
    e.route_node = node[NODE_W-1:0];
    e.turn_code  = turn;
    e.last       = fin[0];
    decision_q.push_back(e);
  endfunction

  function automatic void emit_leg(int unsigned leg, int unsigned len, int unsigned cur);
    int unsigned d;
    for (int unsigned i = 0; i + 1 < len; i++) begin
      d = heading_to(trip_buf[i], trip_buf[i+1]);
      push_decision(leg, trip_buf[i], turn_between(cur, d), 0);
      cur = d;
    end
    push_decision(leg, trip_buf[len-1], TURN_END, leg);
  endfunction

  // apply one accepted request to the mirrored map and queue its decisions
  function automatic void predict_trip(request_t r);
    int unsigned a, b, ia, ib, d, c1, c2, l1, l2, entry, exit_n, len, mid;
    int unsigned r1 [NODES];
    int unsigned r2 [NODES];
    a  = r.node_a;
    b  = r.node_b;
    ia = r.item_end_a;
    ib = r.item_end_b;
    if (r.req_type == REQ_BLOCK || r.req_type == REQ_UNBLOCK) begin
      if (a >= NODES || b >= NODES) return;
      d = heading_to(a, b);
      if (d >= 4) return;
      open_map[a][d]         = (r.req_type == REQ_UNBLOCK);
      open_map[b][(d+2) & 3] = (r.req_type == REQ_UNBLOCK);
      return;
    end
    if (r.req_type != REQ_PLAN || a >= NODES || ia >= NODES || ib >= NODES) return;
    plans_taken++;
    c1 = cheapest_path(a, ia, r.heading);
    r1 = path_buf;
    l1 = path_len;
    c2 = cheapest_path(a, ib, r.heading);
    r2 = path_buf;
    l2 = path_len;
    if (c1 <= c2) begin
      entry = ia; exit_n = ib; len = l1;
      for (int unsigned i = 0; i < len; i++) trip_buf[i] = r1[i];
    end else begin
      entry = ib; exit_n = ia; len = l2;
      for (int unsigned i = 0; i < len; i++) trip_buf[i] = r2[i];
    end
    trip_buf[len] = exit_n;
    len++;
    emit_leg(0, len, r.heading);
    mid = heading_to(entry, exit_n);
    c1 = cheapest_path(exit_n, HOME, mid);
    r1 = path_buf;
    l1 = path_len;
    c2 = cheapest_path(entry, HOME, mid) + BACK_COST;
    r2 = path_buf;
    l2 = path_len;
    if (c1 <= c2) begin
      for (int unsigned i = 0; i < l1; i++) trip_buf[i] = r1[i];
      emit_leg(1, l1, mid);
    end else begin
      long_turnrounds++;
      push_decision(1, exit_n, TURN_BACK, 0);
      for (int unsigned i = 0; i < l2; i++) trip_buf[i] = r2[i];
      emit_leg(1, l2, mid < 4 ? ((mid + 2) & 3) : NO_HEAD);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("MISMATCH %s: got %0d, want %0d (decision %0d)", what, got, want, decisions_seen);
  endtask

  function automatic void queue_req(logic [REQ_W-1:0] rt, int unsigned a, int unsigned b,
                                    int unsigned h, int unsigned ia, int unsigned ib,
                                    bit drain = 1'b0);
    request_t r;
    r.req_type   = rt;
    r.node_a     = a[NODE_W-1:0];
    r.node_b     = b[NODE_W-1:0];
    r.heading    = h[HEAD_W-1:0];
    r.item_end_a = ia[NODE_W-1:0];
    r.item_end_b = ib[NODE_W-1:0];
    r.drain      = drain;
    pending_q.push_back(r);
  endfunction

  // pick a real edge of the grid, the home link among them
  function automatic void random_edge(output int unsigned u, output int unsigned v);
    int unsigned d;
    do begin
      u = $urandom_range(0, HOME);
      d = $urandom_range(0, 3);
      v = next_node(u, d);
    end while (v == NO_NODE);
  endfunction

  function automatic int unsigned random_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver: offer queued items, hold each until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_trip(on_wire);
        items_taken++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the current transfer
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && (decision_q.size() > 0 ||
                                            (req_ch.valid && req_ch.ready)))) begin
        on_wire = pending_q.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= on_wire.req_type;
        req_ch.node_a     <= on_wire.node_a;
        req_ch.node_b     <= on_wire.node_b;
        req_ch.heading    <= on_wire.heading;
        req_ch.item_end_a <= on_wire.item_end_a;
        req_ch.item_end_b <= on_wire.item_end_b;
        gap_left = (items_taken / 30) % 2 == 1 ? 0 : random_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // decision monitor: stall at random, compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dec_ch.ready <= 1'b0;
    end else begin
      if (dec_ch.valid && dec_ch.ready) begin
        if (decision_q.size() == 0) begin
          errors++;
          $display("UNEXPECTED decision node %0d turn %0d", dec_ch.route_node, dec_ch.turn_code);
        end else begin
          decision_t e;
          e = decision_q.pop_front();
          if (dec_ch.leg !== e.leg) report_mismatch("leg", dec_ch.leg, e.leg);
          if (dec_ch.route_node !== e.route_node)
            report_mismatch("route_node", dec_ch.route_node, e.route_node);
          if (dec_ch.turn_code !== e.turn_code)
            report_mismatch("turn_code", dec_ch.turn_code, e.turn_code);
          if (dec_ch.last !== e.last) report_mismatch("last", dec_ch.last, e.last);
        end
        decisions_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        dec_ch.ready <= 1'b0;
      end else begin
        dec_ch.ready <= !hold_sink;
        stall_left = (decisions_seen / 100) % 2 == 1 ? 0 : random_gap();
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_route_planner_turn_penalty_tb: done, errors");
      $finish;
    end
  end

  // long hold-off on the decision side while requests keep coming
  initial begin
    hold_sink = 1'b0;
    wait (items_taken >= 40);
    @(posedge clk_i);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  initial begin
    int unsigned u, v, p, ia, ib;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PLAN;
    req_ch.node_a = '0;
    req_ch.node_b = '0;
    req_ch.heading = '0;
    req_ch.item_end_a = '0;
    req_ch.item_end_b = '0;
    dec_ch.ready = 1'b0;
    reset_map();

    // directed: edges of the field ranges and the awkward cases
    queue_req(REQ_PLAN, 0, 0, HEAD_N, 0, 1);
    queue_req(REQ_PLAN, 24, 31, HEAD_W, 23, 24);
    queue_req(REQ_PLAN, 0, 0, HEAD_E, 0, 1);
    queue_req(REQ_PLAN, HOME, 0, HEAD_S, 12, 13);
    queue_req(REQ_PLAN, 12, 0, HEAD_E, 7, 7);
    queue_req(REQ_PLAN, 6, 0, HEAD_S, 3, 21);
    queue_req(REQ_PLAN, 26, 0, HEAD_N, 1, 2);
    queue_req(REQ_PLAN, 4, 0, HEAD_N, 31, 2);
    queue_req(REQ_PLAN, 4, 0, HEAD_N, 2, HOME);
    queue_req(REQ_SPARE, 1, 2, HEAD_E, 3, 4);
    queue_req(REQ_BLOCK, 3, 9, HEAD_N, 0, 0);
    queue_req(REQ_UNBLOCK, 0, 6, HEAD_N, 0, 0);
    queue_req(REQ_BLOCK, 31, 30, HEAD_N, 0, 0);
    queue_req(REQ_BLOCK, 0, HOME, HEAD_N, 0, 0);
    queue_req(REQ_PLAN, 18, 0, HEAD_W, 17, 18);
    queue_req(REQ_UNBLOCK, HOME, 0, HEAD_N, 0, 0);
    queue_req(REQ_BLOCK, 23, 24, HEAD_N, 0, 0);
    queue_req(REQ_BLOCK, 19, 24, HEAD_N, 0, 0);
    queue_req(REQ_PLAN, 2, 0, HEAD_S, 24, 19);
    queue_req(REQ_UNBLOCK, 24, 23, HEAD_N, 0, 0);
    queue_req(REQ_UNBLOCK, 24, 19, HEAD_N, 0, 0, 1'b1);
    queue_req(REQ_PLAN, 1, 0, HEAD_E, 1, 2);

    // random: mostly plans on real item edges, some map edits, some noise
    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        random_edge(ia, ib);
        if (ia == HOME) ia = ib + 1 < HOME ? ib + 1 : ib - 1;
        if (ib == HOME) ib = ia + 1 < HOME ? ia + 1 : ia - 1;
        if ($urandom_range(0, 9) == 0) ib = $urandom_range(0, HOME - 1);
        queue_req(REQ_PLAN, $urandom_range(0, HOME), $urandom_range(0, 31),
                  $urandom_range(0, 3), ia, ib, k == 60);
      end else if (p < 68) begin
        random_edge(u, v);
        queue_req(REQ_BLOCK, u, v, $urandom_range(0, 3), $urandom_range(0, 31),
                  $urandom_range(0, 31));
      end else if (p < 85) begin
        random_edge(u, v);
        queue_req(REQ_UNBLOCK, u, v, $urandom_range(0, 3), $urandom_range(0, 31),
                  $urandom_range(0, 31));
      end else begin
        queue_req(REQ_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !req_ch.valid);
    wait (decision_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (decision_q.size() != 0) begin
      errors++;
      $display("%0d decisions never arrived", decision_q.size());
    end

    $display("covered %0d requests, %0d plans, %0d decisions, %0d home legs turning round",
             items_taken, plans_taken, decisions_seen, long_turnrounds);
    if (errors == 0) begin
      $display("grid_route_planner_turn_penalty_tb: done, clean");
    end else begin
      $display("grid_route_planner_turn_penalty_tb: done, errors");
    end
    $finish;
  end

endmodule
